@@ design/dec_pkg.sv @@
`default_nettype none

package dec_pkg;

  // Widths of the configuration port and the registers behind it.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned RUN_W      = 17;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_SAMPLES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL    = 3'd4;

  // Bit positions inside edge_mode.
  localparam int unsigned MODE_NO_RISE = 0;
  localparam int unsigned MODE_NO_FALL = 1;

  // Reset value of step_size.
  localparam logic [COUNT_W-1:0] STEP_SIZE_RST = 16'd1;

  // Live configuration seen by the tracker.
  typedef struct packed {
    logic [COUNT_W-1:0] debounce_samples;
    logic [1:0]         edge_mode;
    logic [COUNT_W-1:0] max_count;
    logic [COUNT_W-1:0] step_size;
  } dec_cfg_t;

  // Set-up request that reloads the debounced level.
  typedef struct packed {
    logic load;
    logic level;
  } dec_setup_t;

  // One result beat.
  typedef struct packed {
    logic [COUNT_W-1:0] count_value;
    logic               debounced_level;
  } dec_result_t;

endpackage

`default_nettype wire

@@ design/dec_if.sv @@
`default_nettype none

// Input channel: one sampled pin level per beat.
interface dec_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

// Result channel: count and debounced level per beat.
interface dec_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] count_value;
  logic        debounced_level;

  modport source (output valid, output count_value, output debounced_level, input ready);
  modport sink   (input valid, input count_value, input debounced_level, output ready);
endinterface

`default_nettype wire

@@ design/dec_cfg_regs.sv @@
`default_nettype none

module dec_cfg_regs
  import dec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output dec_cfg_t                   cfg,
  output dec_setup_t                 setup
);

  dec_cfg_t cfg_r;

  // Register file; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_samples <= '0;
      cfg_r.edge_mode        <= '0;
      cfg_r.max_count        <= '0;
      cfg_r.step_size        <= STEP_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_SAMPLES: cfg_r.debounce_samples <= cfg_wdata;
        REG_EDGE_MODE:        cfg_r.edge_mode        <= cfg_wdata[1:0];
        REG_MAX_COUNT:        cfg_r.max_count        <= cfg_wdata;
        REG_STEP_SIZE:        cfg_r.step_size        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  // Writing initial_level reloads the debounced level and clears the run counter directly.
  assign setup.load  = cfg_we && (cfg_index == REG_INITIAL_LEVEL);
  assign setup.level = cfg_wdata[0];

endmodule

`default_nettype wire

@@ design/dec_tracker.sv @@
`default_nettype none

module dec_tracker
  import dec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic       pin_level,
  input  wire dec_cfg_t   cfg,
  input  wire dec_setup_t setup,
  output dec_result_t     result
);

  logic               stable_r, stable_nxt;
  logic [RUN_W-1:0]   run_r, run_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               differs;
  logic [RUN_W-1:0]   run_inc;
  logic               flip;
  logic               counted;
  logic [COUNT_W:0]   sum;
  logic               clip;
  logic [COUNT_W-1:0] count_add;

  // Debounce decision and the add for one sample, saturating at max_count when it is nonzero.
  always_comb begin
    differs   = (pin_level != stable_r);
    run_inc   = run_r + RUN_W'(1);
    flip      = differs && (run_inc > {1'b0, cfg.debounce_samples});
    counted   = flip && (pin_level ? !cfg.edge_mode[MODE_NO_RISE]
                                   : !cfg.edge_mode[MODE_NO_FALL]);
    sum       = {1'b0, count_r} + {1'b0, cfg.step_size};
    clip      = (cfg.max_count != '0) && (sum > {1'b0, cfg.max_count});
    count_add = clip ? cfg.max_count : sum[COUNT_W-1:0];

    stable_nxt = flip ? pin_level : stable_r;
    run_nxt    = (differs && !flip) ? run_inc : '0;
    count_nxt  = counted ? count_add : count_r;
  end

  // State moves on each accepted beat; a set-up write reloads the level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      run_r    <= '0;
      count_r  <= '0;
    end else if (setup.load) begin
      stable_r <= setup.level;
      run_r    <= '0;
    end else if (accept) begin
      stable_r <= stable_nxt;
      run_r    <= run_nxt;
      count_r  <= count_nxt;
    end
  end

  assign result.count_value     = count_nxt;
  assign result.debounced_level = stable_nxt;

endmodule

`default_nettype wire

@@ design/dec_out_stage.sv @@
`default_nettype none

module dec_out_stage
  import dec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire dec_result_t result,
  input  wire logic        out_ready,
  output logic             can_load,
  output logic             out_valid,
  output dec_result_t      out_data
);

  logic        valid_r, valid_nxt;
  dec_result_t data_r;

  // The register takes a new beat when empty or being drained this cycle.
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ design/debounced_edge_counter_core.sv @@
`default_nettype none

// Channel   Role    Beat contents
// in_ch     sink    pin_level
// out_ch    source  count_value, debounced_level
// cfg_*     write   cfg_index selects the register, cfg_wdata carries its value
//
// One sample per cycle while the output is not stalled: each accepted beat updates the
// state, and its result is loaded into the output register together with that update.
// Synchronous active-low reset clears the state, the count and the output valid.
// A stalled output keeps in_ch.ready low only while the output register is full
// and not being drained; one result is delivered per sample, in order.

module debounced_edge_counter_core
  import dec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  dec_in_if.sink                     in_ch,
  dec_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  dec_cfg_t    cfg;
  dec_setup_t  setup;
  dec_result_t result;
  dec_result_t out_data;
  logic        can_load;
  logic        accept;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  dec_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .setup     (setup)
  );

  dec_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .pin_level (in_ch.pin_level),
    .cfg       (cfg),
    .setup     (setup),
    .result    (result)
  );

  dec_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .result    (result),
    .out_ready (out_ch.ready),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_data  (out_data)
  );

  assign out_ch.count_value     = out_data.count_value;
  assign out_ch.debounced_level = out_data.debounced_level;

endmodule

`default_nettype wire
